>>> hw/rtl/hrlf_pkg.sv
// package for the http request length finder
// holds scan constants, the name table and the stage-to-stage result struct
// no dependencies
package hrlf_pkg;

    // scan window for the blank line that ends the headers
    localparam int MAX_SCAN = 512;
    // width of a header length, enough to hold MAX_SCAN itself
    localparam int HDR_W = $clog2(MAX_SCAN + 1);

    localparam int NAME_LEN = 15;
    localparam int NAME_POS_W = 4;
    localparam int DIGIT_WINDOW = 16;
    localparam int DIGIT_CNT_W = 5;

    localparam int LEN_W = 32;
    localparam int HDR_OUT_W = 10;
    // complete flag, request length, header length, padded to whole bytes
    localparam int OUT_FIELDS_W = 1 + LEN_W + HDR_OUT_W;
    localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    // last three bytes before the final lf of a blank line
    localparam logic [23:0] BLANK_TAIL = 24'h0D0A0D;

    // totals of one request, handed from the scan to the result stage
    typedef struct packed {
        logic              seen;
        logic [HDR_W-1:0]  hdr;
        logic [LEN_W-1:0]  body;
        logic [LEN_W-1:0]  total;
    } t_fin;

    // lower-case a letter, other bytes pass
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    // characters of "content-length:"
    function automatic logic [7:0] name_char(input logic [NAME_POS_W-1:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = 8'h63; // c
            4'd1:    r = 8'h6F; // o
            4'd2:    r = 8'h6E; // n
            4'd3:    r = 8'h74; // t
            4'd4:    r = 8'h65; // e
            4'd5:    r = 8'h6E; // n
            4'd6:    r = 8'h74; // t
            4'd7:    r = 8'h2D; // -
            4'd8:    r = 8'h6C; // l
            4'd9:    r = 8'h65; // e
            4'd10:   r = 8'h6E; // n
            4'd11:   r = 8'h67; // g
            4'd12:   r = 8'h74; // t
            4'd13:   r = 8'h68; // h
            4'd14:   r = 8'h3A; // :
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/hrlf_scan.sv
// per-byte scan state: blank line search, header name match, digit collection
// depends on hrlf_pkg; returns to reset state after the last byte of a request
module hrlf_scan
    import hrlf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_fin       o_fin
);

    logic [LEN_W-1:0]       r_pos, n_pos;
    logic [23:0]            r_recent, n_recent;
    logic [HDR_W-1:0]       r_hdr, n_hdr;
    logic                   r_seen, n_seen;
    logic [NAME_POS_W-1:0]  r_match, n_match;
    logic                   r_line_start, n_line_start;
    logic                   r_found, n_found;
    logic [DIGIT_CNT_W-1:0] r_digits_left, n_digits_left;
    logic [LEN_W-1:0]       r_body, n_body;

    logic is_eol;
    logic is_digit;
    logic name_hit;

    assign is_eol   = (i_byte == CHAR_CR) || (i_byte == CHAR_LF);
    assign is_digit = (i_byte >= CHAR_0) && (i_byte <= CHAR_9);
    assign name_hit = !r_found && !r_seen && ((r_match != '0) || r_line_start) &&
                      (r_match < NAME_POS_W'(NAME_LEN)) &&
                      (to_lower(i_byte) == name_char(r_match));

    // next state for one byte
    always_comb begin
        n_body        = r_body;
        n_digits_left = r_digits_left;
        n_found       = r_found;
        n_match       = '0;
        n_seen        = r_seen;
        n_hdr         = r_hdr;

        // value digits, times ten as two shifts and adds
        if (r_digits_left != '0) begin
            if (is_eol) begin
                n_digits_left = '0;
            end else begin
                if (is_digit) begin
                    n_body = (r_body << 3) + (r_body << 1) +
                             {{(LEN_W-4){1'b0}}, i_byte[3:0]};
                end
                n_digits_left = r_digits_left - DIGIT_CNT_W'(1);
            end
        end

        // header name match at line start
        if (name_hit) begin
            if (r_match == NAME_POS_W'(NAME_LEN - 1)) begin
                n_found       = 1'b1;
                n_digits_left = DIGIT_CNT_W'(DIGIT_WINDOW);
                n_match       = '0;
            end else begin
                n_match = r_match + NAME_POS_W'(1);
            end
        end

        // blank line within the scan window
        if (!r_seen && (r_pos < LEN_W'(MAX_SCAN)) && (r_recent == BLANK_TAIL) &&
            (i_byte == CHAR_LF)) begin
            n_seen = 1'b1;
            n_hdr  = r_pos[HDR_W-1:0] + HDR_W'(1);
        end

        n_recent     = {r_recent[15:0], i_byte};
        n_line_start = (i_byte == CHAR_LF);
        n_pos        = (r_pos == '1) ? r_pos : r_pos + LEN_W'(1);
    end

    // totals as they stand after this byte
    assign o_fin.seen  = n_seen;
    assign o_fin.hdr   = n_hdr;
    assign o_fin.body  = n_body;
    assign o_fin.total = n_pos;

    // state registers, cleared again after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos         <= '0;
            r_recent      <= '0;
            r_hdr         <= '0;
            r_seen        <= 1'b0;
            r_match       <= '0;
            r_line_start  <= 1'b1;
            r_found       <= 1'b0;
            r_digits_left <= '0;
            r_body        <= '0;
        end else if (i_en) begin
            r_pos         <= n_pos;
            r_recent      <= n_recent;
            r_hdr         <= n_hdr;
            r_seen        <= n_seen;
            r_match       <= n_match;
            r_line_start  <= n_line_start;
            r_found       <= n_found;
            r_digits_left <= n_digits_left;
            r_body        <= n_body;
        end
    end

endmodule

>>> hw/rtl/hrlf_result.sv
// result stage: holds request totals, adds header and body, checks completeness
// depends on hrlf_pkg; output register feeds the master-side stream
module hrlf_result
    import hrlf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fin_valid,
    input  t_fin             i_fin,
    output logic             o_fin_ready,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [OUT_W-1:0] o_tdata
);

    logic             r_fin_valid;
    t_fin             r_fin;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic             out_ready;
    logic             fin_move;
    logic [LEN_W-1:0] hdr_ext;
    logic [LEN_W-1:0] req_len;
    logic             complete;

    assign out_ready   = !r_out_valid || i_tready;
    assign fin_move    = r_fin_valid && out_ready;
    assign o_fin_ready = !r_fin_valid || out_ready;

    // one wide add and one compare
    assign hdr_ext  = {{(LEN_W-HDR_W){1'b0}}, r_fin.hdr};
    assign req_len  = r_fin.seen ? (hdr_ext + r_fin.body) : '0;
    assign complete = r_fin.seen && (req_len <= r_fin.total);

    // holding register for the totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (o_fin_ready) begin
            r_fin_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_ready && i_fin_valid) begin
            r_fin <= i_fin;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_out_data <= {{(OUT_W-OUT_FIELDS_W){1'b0}},
                           hdr_ext[HDR_OUT_W-1:0], req_len, complete};
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a header that ended holds at least the four blank-line bytes
    a_hdr_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && r_fin.seen |-> r_fin.hdr >= HDR_W'(4))
        else $error("header length below four with blank line seen");

    // no blank line, no header length
    a_hdr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !r_fin.seen |-> r_fin.hdr == '0)
        else $error("header length set without blank line");

    // held totals are not overwritten while the output stalls
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !out_ready |=> r_fin_valid && $stable(r_fin))
        else $error("pending totals lost under stall");
`endif

endmodule

>>> hw/rtl/http_request_length_finder.sv
// top level of the http request length finder
// depends on hrlf_pkg, hrlf_scan, hrlf_result
//
// channel   dir  tdata fields (low bit up)                       tlast
// s_axis    in   data_byte[7:0]                                  is_last
// m_axis    out  request_complete, request_length[31:0],         -
//                header_length[9:0], zero pad to 48 bits
//
// one byte is taken every cycle while no last byte is held; the scan state updates
// once per byte in the scan stage, the add and compare sit in the result stage
// one result per request, registered in the input, holding and output registers in turn
// a non-last byte leaves the input register in the next cycle; a last byte waits
// only while both result registers are full and the receiver holds off,
// so stalls reach the input only through a held result
// synchronous active-low reset clears all stream control and scan state
module http_request_length_finder
    import hrlf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,  // data_byte[7:0]
    input  logic             i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata   // complete, length[31:0], header[9:0]
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       fin_ready;
    logic       s0_go;
    t_fin       fin;

    // input register drains unless a last byte meets a full result stage
    assign s0_go           = r_in_valid && (!r_in_last || fin_ready);
    assign o_s_axis_tready = !r_in_valid || s0_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // per-byte scan
    hrlf_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s0_go),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_fin   (fin)
    );

    // totals and output register
    hrlf_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (s0_go && r_in_last),
        .i_fin       (fin),
        .o_fin_ready (fin_ready),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata)
    );

endmodule

>>> verif/testbench.sv
// stream-level testbench for http_request_length_finder
// runs whole request buffers through the block and checks each reported length
// depends on hrlf_pkg and the rtl of http_request_length_finder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hrlf_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 400;
    localparam int STEADY_BYTES = 200;
    localparam int IDLE_PERCENT = 16;
    localparam bit [8*NAME_LEN-1:0] LENGTH_NAME = "content-length:";

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [7:0]       i_s_axis_tdata;   // data_byte[7:0]
    logic             i_s_axis_tlast;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;   // complete, length[31:0], header[9:0]

    // what one request buffer should report
    typedef struct {
        bit                 complete;
        bit [LEN_W-1:0]     req_len;
        bit [HDR_OUT_W-1:0] hdr_len;
    } t_request_totals;

    // length scanner model and the queue of totals still owed by the block
    class length_scoreboard;
        bit [31:0]       byte_count;
        bit [23:0]       tail;
        bit [31:0]       hdr_end;
        bit              hdr_done;
        int unsigned     name_pos;
        bit              at_line_start;
        bit              len_found;
        int unsigned     digits_left;
        bit [31:0]       body_len;
        t_request_totals pending[$];
        int unsigned     errors;
        int unsigned     results_checked;

        function new();
            errors = 0;
            results_checked = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            byte_count = 0;
            tail = 0;
            hdr_end = 0;
            hdr_done = 0;
            name_pos = 0;
            at_line_start = 1;
            len_found = 0;
            digits_left = 0;
            body_len = 0;
        endfunction

        // one byte transfer accepted at the input
        function void note_byte(input bit [7:0] b, input bit last);
            bit [7:0]        lc;
            bit [7:0]        want;
            bit [31:0]       pos;
            t_request_totals totals;
            pos = byte_count;

            // value digits of the length line, cut short by cr or lf
            if (digits_left > 0) begin
                if (b == CHAR_CR || b == CHAR_LF) begin
                    digits_left = 0;
                end else begin
                    if (b >= CHAR_0 && b <= CHAR_9) begin
                        body_len = body_len * 32'd10 + {24'd0, b - CHAR_0};
                    end
                    digits_left--;
                end
            end

            // header name, case folded, only from the start of a header line
            lc = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
            want = (name_pos < NAME_LEN) ? LENGTH_NAME[8*(NAME_LEN-1-name_pos) +: 8] : 8'h00;
            if (!len_found && !hdr_done && (name_pos > 0 || at_line_start)
                    && name_pos < NAME_LEN && lc == want) begin
                name_pos++;
                if (name_pos == NAME_LEN) begin
                    len_found = 1;
                    digits_left = DIGIT_WINDOW;
                    name_pos = 0;
                end
            end else begin
                name_pos = 0;
            end

            // crlfcrlf ending inside the scan window
            if (!hdr_done && pos < MAX_SCAN && tail == BLANK_TAIL && b == CHAR_LF) begin
                hdr_done = 1;
                hdr_end = pos + 1;
            end

            tail = {tail[15:0], b};
            at_line_start = (b == CHAR_LF);
            if (byte_count != 32'hFFFF_FFFF) begin
                byte_count++;
            end

            if (last) begin
                totals.complete = 0;
                totals.req_len = 0;
                totals.hdr_len = 0;
                if (hdr_done) begin
                    totals.req_len = hdr_end + body_len;
                    totals.complete = (totals.req_len <= byte_count);
                    totals.hdr_len = hdr_end[HDR_OUT_W-1:0];
                end
                pending.push_back(totals);
                clear_scan();
            end
        endfunction

        // one result transfer accepted at the output
        function void check_result(input logic [OUT_W-1:0] d);
            logic                 got_complete;
            logic [LEN_W-1:0]     got_len;
            logic [HDR_OUT_W-1:0] got_hdr;
            t_request_totals      exp_totals;
            got_complete = d[0];
            got_len = d[LEN_W:1];
            got_hdr = d[LEN_W+HDR_OUT_W:LEN_W+1];
            results_checked++;
            if (pending.size() == 0) begin
                $error("result with no request pending: tdata 0x%h", d);
                errors++;
                return;
            end
            exp_totals = pending.pop_front();
            if (got_complete !== exp_totals.complete) begin
                $error("request_complete: expected %0d actual %0d",
                       exp_totals.complete, got_complete);
                errors++;
            end
            if (got_len !== exp_totals.req_len) begin
                $error("request_length: expected %0d actual %0d",
                       exp_totals.req_len, got_len);
                errors++;
            end
            if (got_hdr !== exp_totals.hdr_len) begin
                $error("header_length: expected %0d actual %0d",
                       exp_totals.hdr_len, got_hdr);
                errors++;
            end
        endfunction
    endclass

    length_scoreboard sb;
    bit [7:0]         req_bytes[$];
    bit               steady;
    bit               hold_off_req;
    int unsigned      cycle_count;
    int unsigned      random_bytes_sent;

    http_request_length_finder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // input and output transfer monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            sb.note_byte(i_s_axis_tdata, i_s_axis_tlast);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 0;
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // offer one byte, with random gaps, and wait for its transfer
    task automatic send_byte(input bit [7:0] b, input bit last);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = b;
        i_s_axis_tlast = last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // send the built buffer, last mark on its final byte
    task automatic send_request();
        foreach (req_bytes[i]) begin
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
        end
        req_bytes.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            req_bytes.push_back(s[i]);
        end
    endtask

    task automatic add_repeat(input bit [7:0] b, input int n);
        repeat (n) req_bytes.push_back(b);
    endtask

    // header name with letters in random case
    task automatic add_name_mixed();
        bit [7:0] c;
        for (int i = 0; i < NAME_LEN; i++) begin
            c = LENGTH_NAME[8*(NAME_LEN-1-i) +: 8];
            if (c >= "a" && c <= "z" && $urandom_range(1)) begin
                c = c - 8'h20;
            end
            req_bytes.push_back(c);
        end
    endtask

    task automatic add_printable(input int n);
        repeat (n) req_bytes.push_back(8'($urandom_range(32, 126)));
    endtask

    task automatic add_any(input int n);
        repeat (n) req_bytes.push_back(8'($urandom_range(255)));
    endtask

    // mostly well-formed requests with random content, some broken, some noise
    task automatic build_random_request();
        int          kind;
        int          n_hdrs;
        int          len_at;
        int          body;
        bit [31:0]   value;
        int          cut;
        kind = $urandom_range(99);
        if (kind >= 85) begin
            add_any($urandom_range(1, 30));
            return;
        end
        add_text("GET /");
        add_printable($urandom_range(0, 4));
        add_text(" HTTP/1.1\r\n");
        n_hdrs = $urandom_range(0, 3);
        len_at = ($urandom_range(3) == 0) ? -1 : $urandom_range(0, n_hdrs);
        value = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(60));
        for (int h = 0; h <= n_hdrs; h++) begin
            if (h == len_at) begin
                add_name_mixed();
                if ($urandom_range(1)) add_text(" ");
                add_text($sformatf("%0d", value));
                if ($urandom_range(7) == 0) add_printable($urandom_range(1, 4));
                add_text("\r\n");
            end
            if (h < n_hdrs) begin
                add_text("X-");
                add_printable($urandom_range(0, 8));
                add_text("\r\n");
            end
        end
        add_text("\r\n");
        body = (value <= 60) ? int'(value) : $urandom_range(60);
        body = body + $urandom_range(0, 4) - 2;
        if (body > 0) add_any(body);
        if (req_bytes.size() == 0) add_any(1);
        // broken sequences: truncated or with one byte corrupted
        if (kind >= 70) begin
            if ($urandom_range(1)) begin
                cut = $urandom_range(1, req_bytes.size());
                while (req_bytes.size() > cut) void'(req_bytes.pop_back());
            end else begin
                req_bytes[$urandom_range(req_bytes.size() - 1)] = 8'($urandom_range(255));
            end
        end
    endtask

    // main sequence
    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = 8'h00;
        i_s_axis_tlast = 1'b0;
        steady = 0;
        hold_off_req = 0;
        cycle_count = 0;
        random_bytes_sent = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single-byte buffers at the byte extremes
        add_repeat(8'h00, 1); send_request();
        add_repeat(8'hFF, 1); send_request();
        // blank line alone
        add_text("\r\n\r\n"); send_request();
        // no length line, with nul and 0xff bytes inside a header
        add_text("GET / HTTP/1.1\r\nHost: a");
        add_repeat(8'h00, 1); add_repeat(8'hFF, 1);
        add_text("\r\n\r\n"); send_request();
        // body exactly present, then short
        add_text("POST / HTTP/1.1\r\nContent-Length: 5\r\n\r\nhello"); send_request();
        add_text("POST / HTTP/1.1\r\nContent-Length: 5\r\n\r\nhel"); send_request();
        // upper case name at buffer start, extra body bytes
        add_text("CONTENT-LENGTH:12\r\n\r\n"); add_repeat("z", 20); send_request();
        // name in the middle of a line does not count
        add_text("GET /\r\nX: content-length: 9\r\n\r\n"); send_request();
        // name after the blank line is ignored
        add_text("\r\n\r\ncontent-length: 7\r\n"); send_request();
        // blank line never seen
        add_text("GET / HTTP/1.1\r\ncontent-length: 3\r\nabc"); send_request();
        // bare lf lines are not a blank line
        add_text("GET /\n\n\n\n"); send_request();
        // value wraps mod 2^32
        add_text("GET /\r\ncontent-length:9999999999999999\r\n\r\n"); send_request();
        // digits past the window are dropped
        add_text("GET /\r\ncontent-length:12345678901234567890\r\n\r\n"); send_request();
        // non-digits skipped inside the value
        add_text("GET /\r\ncontent-length: 1a2b3\r\n\r\n"); add_any(130); send_request();
        // only the first length line counts
        add_text("GET /\r\ncontent-length: 2\r\nContent-Length: 40\r\n\r\nab");
        send_request();
        // near miss on the name, then the real one
        add_text("GET /\r\ncontent-lengtx: 4\r\ncontent-length: 2\r\n\r\nab");
        send_request();
        // blank line ending on the last byte of the scan window
        add_text("GET /\r\nX-Pad: "); add_repeat("a", MAX_SCAN - 18);
        add_text("\r\n\r\n"); send_request();
        // blank line ending one byte past the window
        add_text("GET /\r\nX-Pad: "); add_repeat("a", MAX_SCAN - 17);
        add_text("\r\n\r\n"); send_request();

        // long receiver hold-off while short buffers keep arriving
        @(posedge i_clk);
        hold_off_req = 1;
        repeat (40) begin
            if ($urandom_range(1)) add_text("\r\n\r\n");
            add_any(1);
            send_request();
        end

        // random requests, the first stretch with no idling on either side
        steady = 1;
        while (random_bytes_sent < RANDOM_BYTES) begin
            if (random_bytes_sent > STEADY_BYTES) steady = 0;
            build_random_request();
            random_bytes_sent += req_bytes.size();
            send_request();
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tlast = 1'b0;
        steady = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
